/* src/fqwr_pkg.sv */
// Package for the tag queue with remove-by-key.
// Holds sizes, opcode and status codes, and the command/result structs.
// No dependencies.
package fqwr_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH   = 2;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SEARCH,
      ENG_SHIFT,
      ENG_REPLY
   } eng_state_type;

   typedef struct packed {
      op_type               op;
      logic [TAG_WIDTH-1:0] tag;
      logic                 takes_tag;   // dequeue or remove hands a tag back
   } cmd_type;

   typedef struct packed {
      status_type           status;
      logic [TAG_WIDTH-1:0] tag_out;
      logic                 found;
      logic [CNT_W-1:0]     count;
   } rsp_type;

endpackage

/* src/fqwr_front.sv */
// Front end: accepts request transactions, decodes the opcode and buffers
// commands for the engine. Depends on fqwr_pkg.
module fqwr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_opcode,
   input  logic [fqwr_pkg::TAG_WIDTH-1:0] req_item_tag,
   output logic                          cmd_valid,
   input  logic                          cmd_pop,
   output fqwr_pkg::cmd_type             cmd
);
   import fqwr_pkg::*;

   cmd_type              buf_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wptr_ff, wptr_in;
   logic [CMD_PTR_W-1:0] rptr_ff, rptr_in;
   logic [CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;
   cmd_type              dec;

   always_comb begin
      dec.op        = op_type'(req_opcode);
      dec.tag       = req_item_tag;
      dec.takes_tag = (dec.op == OP_DEQ) || (dec.op == OP_REMOVE);
   end

   assign full      = (cnt_ff == CMD_CNT_W'(CMD_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = buf_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_ff + CMD_PTR_W'(1);
      end
      cnt_in = cnt_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wptr_ff] <= dec;
      end
   end

endmodule

/* src/fqwr_rsp_q.sv */
// Result queue between the engine and the response ports.
// Depends on fqwr_pkg.
module fqwr_rsp_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  fqwr_pkg::rsp_type wr_data,
   output logic              wr_full,
   output logic              empty,
   input  logic              pop,
   output fqwr_pkg::rsp_type head
);
   import fqwr_pkg::*;

   rsp_type              buf_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RSP_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign wr_full = (cnt_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = buf_ff[rptr_ff];
   assign do_push = wr_en && !wr_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wptr_ff + RSP_PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rptr_ff + RSP_PTR_W'(1);
      end
      cnt_in = cnt_ff + RSP_CNT_W'(do_push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

/* src/fqwr_engine.sv */
// Back end: owns the tag memory and occupancy, runs the search and the
// gap-closing shift one entry per cycle. Depends on fqwr_pkg.
module fqwr_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  fqwr_pkg::cmd_type cmd,
   output logic              rsp_push,
   input  logic              rsp_full,
   output fqwr_pkg::rsp_type rsp
);
   import fqwr_pkg::*;

   logic [TAG_WIDTH-1:0] mem [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 we;
   logic [IDX_W-1:0]     wr_addr;
   logic [TAG_WIDTH-1:0] wr_data;

   eng_state_type        state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;          // next entry to read
   logic                 chk_ff, chk_in;          // rd_data_ff holds a live read
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;  // which entry it came from
   status_type           status_ff, status_in;
   logic [TAG_WIDTH-1:0] tag_out_ff, tag_out_in;
   logic                 found_ff, found_in;
   logic                 hit;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // dequeue takes whatever comes back first; the others match on tag
   assign hit = chk_ff && ((cmd_ff.op == OP_DEQ) || (rd_data_ff == cmd_ff.tag));

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      status_in  = status_ff;
      tag_out_in = tag_out_ff;
      found_in   = found_ff;
      rd_addr    = idx_ff[IDX_W-1:0];
      we         = 1'b0;
      wr_addr    = occ_ff[IDX_W-1:0];
      wr_data    = cmd_ff.tag;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;

      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cmd_in     = cmd;
               idx_in     = '0;
               tag_out_in = '0;
               found_in   = 1'b0;
               state_in   = ENG_SEARCH;
            end
         end

         ENG_SEARCH: begin
            if (hit) begin
               found_in = 1'b1;
               if (cmd_ff.takes_tag) begin
                  tag_out_in = rd_data_ff;
                  idx_in     = CNT_W'(chk_idx_ff) + CNT_W'(1);
                  state_in   = ENG_SHIFT;
               end else begin
                  state_in = ENG_REPLY;
                  if (cmd_ff.op == OP_ENQ) begin
                     if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        we        = 1'b1;
                        occ_in    = occ_ff + CNT_W'(1);
                        status_in = ST_OK;
                     end
                  end else begin
                     status_in = ST_OK;
                  end
               end
            end else if (idx_ff >= occ_ff) begin
               // scanned everything held without a match
               state_in = ENG_REPLY;
               if (cmd_ff.op == OP_ENQ) begin
                  if (occ_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     we        = 1'b1;
                     occ_in    = occ_ff + CNT_W'(1);
                     status_in = ST_OK;
                  end
               end else begin
                  status_in = ST_MISS;
               end
            end else begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end
         end

         ENG_SHIFT: begin
            // read entry i, write it to i-1 on the next cycle
            if (chk_ff) begin
               we      = 1'b1;
               wr_addr = chk_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end
            if (idx_ff < occ_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + CNT_W'(1);
            end else if (!chk_ff) begin
               occ_in    = occ_ff - CNT_W'(1);
               status_in = ST_OK;
               state_in  = ENG_REPLY;
            end
         end

         ENG_REPLY: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ENG_IDLE;
            end
         end

         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.status  = status_ff;
      rsp.tag_out = tag_out_ff;
      rsp.found   = found_ff;
      rsp.count   = occ_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
         occ_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      tag_out_ff <= tag_out_in;
      found_ff   <= found_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      ##1 (occ_ff == $past(occ_ff) || occ_ff == $past(occ_ff) + CNT_W'(1)
           || occ_ff == $past(occ_ff) - CNT_W'(1)))
      else $error("occupancy moved by more than one");

   a_read_live: assert property (@(posedge clock) disable iff (reset)
      chk_ff |-> (CNT_W'(chk_idx_ff) < occ_ff))
      else $error("read of an entry at or above occupancy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_IDLE) |-> !chk_ff)
      else $error("read still in flight while idle");

   a_occ_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> (state_ff == ENG_REPLY))
      else $error("occupancy changed outside a finishing step");

endmodule

/* src/fifo_queue_with_remove.sv */
// Ordered tag queue with remove-by-key. Requests (enqueue, dequeue, remove,
// query) are taken through a two-entry command queue and carried out by an
// engine that holds the tags in a single-port-read memory, head at entry 0;
// results leave through a two-entry result queue, one per request, each with
// the count after the operation. The engine reads one entry per cycle: an
// enqueue or query scans entries up to the first match, or every held entry
// on a miss, and a dequeue or remove also moves every later entry one place
// toward the head, one per cycle.
// Depends on fqwr_pkg, fqwr_front, fqwr_engine and fqwr_rsp_q.
module fifo_queue_with_remove (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [1:0]                     req_opcode,
   input  logic [fqwr_pkg::TAG_WIDTH-1:0] req_item_tag,
   output logic                           empty,
   input  logic                           pop,
   output logic [1:0]                     rsp_status,
   output logic [fqwr_pkg::TAG_WIDTH-1:0] rsp_tag_out,
   output logic                           rsp_found,
   output logic [fqwr_pkg::CNT_W-1:0]     rsp_count
);
   import fqwr_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   logic    eng_push;
   logic    eng_full;
   rsp_type eng_rsp;
   rsp_type head;

   fqwr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_opcode   (req_opcode),
      .req_item_tag (req_item_tag),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd)
   );

   fqwr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_push  (eng_push),
      .rsp_full  (eng_full),
      .rsp       (eng_rsp)
   );

   fqwr_rsp_q u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (eng_push),
      .wr_data (eng_rsp),
      .wr_full (eng_full),
      .empty   (empty),
      .pop     (pop),
      .head    (head)
   );

   assign rsp_status  = head.status;
   assign rsp_tag_out = head.tag_out;
   assign rsp_found   = head.found;
   assign rsp_count   = head.count;

endmodule

/* tb/fifo_queue_with_remove_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for fifo_queue_with_remove: directed table, then random traffic,
// every result checked against a typed-in result or a shadow copy of the tag queue.
// Depends on fqwr_pkg and the fifo_queue_with_remove RTL.
module fifo_queue_with_remove_tb;
   import fqwr_pkg::*;

   localparam int N_RANDOM        = 600;
   localparam int N_DIR_ROWS      = 17;
   localparam int WATCHDOG_CYCLES = 4000;
   localparam int DRAIN_CYCLES    = 2 * (QUEUE_DEPTH + 6);

   typedef struct packed {
      op_type               op;
      logic [TAG_WIDTH-1:0] tag;
      logic [4:0]           reps;   // rows with reps > 1 step the tag by one each time
      logic                 chk;    // typed-in result below is used
      rsp_type              want;
   } dir_row_type;

   typedef struct {
      op_type               op;
      logic [TAG_WIDTH-1:0] tag;
      logic                 chk;
      rsp_type              want;
   } cmd_item_type;

   logic                 clock;
   logic                 reset;
   logic                 push         = 1'b0;
   logic [1:0]           req_opcode   = 2'd0;
   logic [TAG_WIDTH-1:0] req_item_tag = '0;
   logic                 pop          = 1'b0;
   logic                 full;
   logic                 empty;
   logic [1:0]           rsp_status;
   logic [TAG_WIDTH-1:0] rsp_tag_out;
   logic                 rsp_found;
   logic [CNT_W-1:0]     rsp_count;

   fifo_queue_with_remove u_top (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_opcode   (req_opcode),
      .req_item_tag (req_item_tag),
      .empty        (empty),
      .pop          (pop),
      .rsp_status   (rsp_status),
      .rsp_tag_out  (rsp_tag_out),
      .rsp_found    (rsp_found),
      .rsp_count    (rsp_count)
   );

   // shadow copy of the tag queue, head at index 0
   logic [TAG_WIDTH-1:0] shadow_tags [QUEUE_DEPTH];
   int                   shadow_occ = 0;

   cmd_item_type cmd_items [$];
   rsp_type      pending_rsps [$];
   dir_row_type  dir_tbl [N_DIR_ROWS];
   bit           stim_ready = 1'b0;
   int           n_sent     = 0;
   int           n_rsp      = 0;
   int           n_err      = 0;
   int           quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic note_err(input string msg);
      n_err++;
      if (n_err <= 10) $display("MISMATCH: %s", msg);
   endtask

   task automatic shadow_apply(input op_type op, input logic [TAG_WIDTH-1:0] tag,
                               output rsp_type r);
      int pos;
      int del;
      int i;
      pos = shadow_occ;
      del = -1;
      for (i = 0; i < shadow_occ; i++)
         if (pos == shadow_occ && shadow_tags[i] == tag) pos = i;
      r.status  = ST_OK;
      r.tag_out = '0;
      r.found   = 1'b0;
      case (op)
         OP_ENQ: begin
            r.found = (pos < shadow_occ);
            if (shadow_occ >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_tags[shadow_occ] = tag;
               shadow_occ++;
            end
         end
         OP_DEQ: begin
            if (shadow_occ == 0) begin
               r.status = ST_MISS;
            end else begin
               r.tag_out = shadow_tags[0];
               r.found   = 1'b1;
               del       = 0;
            end
         end
         OP_REMOVE: begin
            if (pos < shadow_occ) begin
               r.tag_out = shadow_tags[pos];
               r.found   = 1'b1;
               del       = pos;
            end else begin
               r.status = ST_MISS;
            end
         end
         default: begin
            if (pos < shadow_occ) r.found = 1'b1;
            else r.status = ST_MISS;
         end
      endcase
      // close the gap, keeping the order of the later entries
      if (del >= 0) begin
         for (i = del; i + 1 < shadow_occ; i++) shadow_tags[i] = shadow_tags[i + 1];
         shadow_occ--;
      end
      r.count = CNT_W'(shadow_occ);
   endtask

   // request side: account for the accepted transaction, then offer the next one
   always @(posedge clock) begin
      rsp_type r;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            shadow_apply(cmd_items[n_sent].op, cmd_items[n_sent].tag, r);
            if (cmd_items[n_sent].chk) pending_rsps.push_back(cmd_items[n_sent].want);
            else pending_rsps.push_back(r);
            n_sent++;
         end
         if (!push || !full) begin
            if (stim_ready && n_sent < cmd_items.size() &&
                ((n_sent >= 250 && n_sent < 400) || $urandom_range(99) >= 35)) begin
               push         <= 1'b1;
               req_opcode   <= cmd_items[n_sent].op;
               req_item_tag <= cmd_items[n_sent].tag;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_rsps.size() == 0) begin
               note_err($sformatf("result %0d arrived with none expected", n_rsp));
            end else begin
               e = pending_rsps.pop_front();
               if (rsp_status !== e.status)
                  note_err($sformatf("result %0d status exp %0d got %0d",
                                     n_rsp, e.status, rsp_status));
               if (rsp_tag_out !== e.tag_out)
                  note_err($sformatf("result %0d tag_out exp %h got %h",
                                     n_rsp, e.tag_out, rsp_tag_out));
               if (rsp_found !== e.found)
                  note_err($sformatf("result %0d found exp %0d got %0d",
                                     n_rsp, e.found, rsp_found));
               if (rsp_count !== e.count)
                  note_err($sformatf("result %0d count exp %0d got %0d",
                                     n_rsp, e.count, rsp_count));
            end
            n_rsp++;
         end
         pop <= (n_rsp >= 250 && n_rsp < 400) || $urandom_range(99) >= 35;
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("fifo_queue_with_remove_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cmd_item_type         c;
      logic [TAG_WIDTH-1:0] pool [12];
      bit                   filling;
      int                   i;
      int                   k;
      int                   pick;

      dir_tbl = '{
         '{OP_DEQ,    16'h0000, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 1'b0, 5'd0}},
         '{OP_REMOVE, 16'hFFFF, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 1'b0, 5'd0}},
         '{OP_QUERY,  16'h0000, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 1'b0, 5'd0}},
         '{OP_ENQ,    16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 1'b0, 5'd1}},
         '{OP_ENQ,    16'h0000, 5'd1,  1'b1, '{ST_OK,   16'h0000, 1'b0, 5'd2}},
         '{OP_QUERY,  16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 1'b1, 5'd2}},
         '{OP_ENQ,    16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 1'b1, 5'd3}},
         '{OP_REMOVE, 16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'hFFFF, 1'b1, 5'd2}},
         '{OP_DEQ,    16'hFFFF, 5'd1,  1'b1, '{ST_OK,   16'h0000, 1'b1, 5'd1}},
         '{OP_ENQ,    16'h5A5A, 5'd15, 1'b0, '{ST_OK,   16'h0000, 1'b0, 5'd0}},
         '{OP_ENQ,    16'h1234, 5'd1,  1'b1, '{ST_FULL, 16'h0000, 1'b0, 5'd16}},
         '{OP_ENQ,    16'hFFFF, 5'd1,  1'b1, '{ST_FULL, 16'h0000, 1'b1, 5'd16}},
         '{OP_REMOVE, 16'h5A61, 5'd1,  1'b0, '{ST_OK,   16'h0000, 1'b0, 5'd0}},
         // tail entry goes, then a fresh enqueue must land behind the new tail
         '{OP_REMOVE, 16'h5A68, 5'd1,  1'b1, '{ST_OK,   16'h5A68, 1'b1, 5'd14}},
         '{OP_QUERY,  16'h5A68, 5'd1,  1'b1, '{ST_MISS, 16'h0000, 1'b0, 5'd14}},
         '{OP_ENQ,    16'h5A68, 5'd1,  1'b0, '{ST_OK,   16'h0000, 1'b0, 5'd0}},
         '{OP_DEQ,    16'h0000, 5'd16, 1'b0, '{ST_OK,   16'h0000, 1'b0, 5'd0}}
      };
      for (i = 0; i < N_DIR_ROWS; i++) begin
         for (k = 0; k < dir_tbl[i].reps; k++) begin
            c.op   = dir_tbl[i].op;
            c.tag  = dir_tbl[i].tag + TAG_WIDTH'(k);
            c.chk  = dir_tbl[i].chk;
            c.want = dir_tbl[i].want;
            cmd_items.push_back(c);
         end
      end
      // closing dequeue on the drained queue
      c.op   = OP_DEQ;
      c.tag  = 16'hFFFF;
      c.chk  = 1'b1;
      c.want = '{ST_MISS, 16'h0000, 1'b0, 5'd0};
      cmd_items.push_back(c);

      // small tag pool so that lookups and removes hit often
      pool[0] = '0;
      pool[1] = '1;
      for (i = 2; i < 12; i++) pool[i] = TAG_WIDTH'($urandom);
      filling = 1'b1;
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 40 == 0) filling = (i % 80 == 0);
         pick = $urandom_range(99);
         if (filling)
            c.op = (pick < 60) ? OP_ENQ : (pick < 75) ? OP_DEQ :
                   (pick < 90) ? OP_REMOVE : OP_QUERY;
         else
            c.op = (pick < 10) ? OP_ENQ : (pick < 55) ? OP_DEQ :
                   (pick < 90) ? OP_REMOVE : OP_QUERY;
         c.tag = ($urandom_range(3) == 0) ? TAG_WIDTH'($urandom) : pool[$urandom_range(11)];
         c.chk = 1'b0;
         cmd_items.push_back(c);
      end
      stim_ready = 1'b1;

      while (n_sent < cmd_items.size() || pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_err == 0) $display("fifo_queue_with_remove_tb: clean");
      else $display("fifo_queue_with_remove_tb: errors");
      $finish;
   end

endmodule

/* fifo_queue_with_remove.f */
src/fqwr_pkg.sv
src/fqwr_front.sv
src/fqwr_rsp_q.sv
src/fqwr_engine.sv
src/fifo_queue_with_remove.sv
tb/fifo_queue_with_remove_tb.sv
